// File: rtl/core/fpe_pkg.sv
// Shared types, constants and plane tables for the frustum plane extraction core.
// No dependencies; used by fpe_ctrl, fpe_dp and frustum_plane_extraction_core.
package fpe_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int SQRT_STEPS    = 49;   // root bits of sqrt(S * 2^32)
  localparam logic [2:0] PLANE_LAST  = 3'd5;
  localparam logic [1:0] COL_TRIGGER = 2'd3;
  localparam logic [1:0] ELEM_LAST   = 2'd3;

  // left, right, bottom, top, near, far
  function automatic logic plane_use3(input logic [2:0] p);
    return (p != 3'd4);
  endfunction

  function automatic logic [1:0] plane_other(input logic [2:0] p);
    logic [1:0] r;
    unique case (p)
      3'd0, 3'd1: r = 2'd0;
      3'd2, 3'd3: r = 2'd1;
      default:    r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic plane_sub(input logic [2:0] p);
    return p[0];
  endfunction

  typedef struct packed {
    logic       col_we;
    logic       load_c3;
    logic       form_v;
    logic       sq_step;
    logic       sqrt_start;
    logic       sqrt_step;
    logic       div_start;
    logic       div_step;
    logic       div_save;
    logic       out_load;
    logic [1:0] k;
    logic [2:0] plane;
  } cmd_t;

  typedef struct packed {
    logic s_zero;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/fpe_ctrl.sv
// Sequencer for the frustum plane extraction core: walks planes, square sums,
// root and division steps. Depends on fpe_pkg.
module fpe_ctrl #(
  parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic [1:0]    in_col,
  output logic          in_tready,
  input  fpe_pkg::sts_t sts,
  output fpe_pkg::cmd_t cmd
);

  localparam int NW    = FRAC_BITS + 51;
  localparam int CNT_W = $clog2(NW);

  typedef enum logic [3:0] {
    S_IDLE, S_FORM, S_SQ, S_ZCHK, S_SQRT, S_DIV_LD, S_DIV, S_DIV_SAVE, S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [2:0]         plane_r, plane_nxt;
  logic [1:0]         k_r, k_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               acc_in;

  assign in_tready = (state_r == S_IDLE);
  assign acc_in    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    plane_nxt = plane_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc_in && in_col == fpe_pkg::COL_TRIGGER) begin
          plane_nxt = 3'd0;
          state_nxt = S_FORM;
        end
      end
      S_FORM: begin
        k_nxt     = 2'd0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        k_nxt = k_r + 2'd1;
        if (k_r == fpe_pkg::ELEM_LAST) state_nxt = S_ZCHK;
      end
      S_ZCHK: begin
        cnt_nxt = '0;
        state_nxt = sts.s_zero ? S_EMIT : S_SQRT;
      end
      S_SQRT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(fpe_pkg::SQRT_STEPS - 1)) begin
          k_nxt     = 2'd0;
          state_nxt = S_DIV_LD;
        end
      end
      S_DIV_LD: begin
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NW - 1)) state_nxt = S_DIV_SAVE;
      end
      S_DIV_SAVE: begin
        k_nxt = k_r + 2'd1;
        state_nxt = (k_r == fpe_pkg::ELEM_LAST) ? S_EMIT : S_DIV_LD;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          plane_nxt = plane_r + 3'd1;
          state_nxt = (plane_r == fpe_pkg::PLANE_LAST) ? S_IDLE : S_FORM;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.k          = k_r;
    cmd.plane      = plane_r;
    cmd.col_we     = acc_in && in_col != fpe_pkg::COL_TRIGGER;
    cmd.load_c3    = acc_in && in_col == fpe_pkg::COL_TRIGGER;
    cmd.form_v     = (state_r == S_FORM);
    cmd.sq_step    = (state_r == S_SQ);
    cmd.sqrt_start = (state_r == S_ZCHK);
    cmd.sqrt_step  = (state_r == S_SQRT);
    cmd.div_start  = (state_r == S_DIV_LD);
    cmd.div_step   = (state_r == S_DIV);
    cmd.div_save   = (state_r == S_DIV_SAVE);
    cmd.out_load   = (state_r == S_EMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      plane_r <= '0;
      k_r     <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      plane_r <= plane_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: rtl/core/fpe_dp.sv
// Datapath of the frustum plane extraction core: column store, plane sums,
// square accumulator, bit-pair square root, serial divider, output register.
// Depends on fpe_pkg.
module fpe_dp #(
  parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fpe_pkg::cmd_t cmd,
  output fpe_pkg::sts_t sts,
  input  logic [127:0]  in_tdata,
  input  logic [1:0]    in_col,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,
  output logic [3:0]    out_tuser,
  output logic          out_tlast
);

  localparam int NW    = FRAC_BITS + 51;   // numerator bits of the rounded divide
  localparam int RT_W  = fpe_pkg::SQRT_STEPS;
  localparam int X_W   = 2 * RT_W;
  localparam int REM_W = RT_W + 3;

  logic signed [31:0] elem [4];
  logic signed [31:0] store_r [3][4];
  logic signed [31:0] c3_r [4];
  logic signed [32:0] v_r [4];
  logic signed [32:0] v_new [4];
  logic [65:0]        prod_r, acc_r;
  logic [65:0]        sq_w;
  logic [X_W-1:0]     x_r;
  logic [REM_W-1:0]   rem_r, rem2, trial;
  logic [RT_W-1:0]    root_r;
  logic [NW-1:0]      num_r;
  logic [RT_W+1:0]    dr_r, dr2, dvs;
  logic [32:0]        q_r;
  logic               ovf_r, neg_r;
  logic [31:0]        res_r [4];
  logic signed [32:0] sel_v;
  logic [32:0]        sel_mag;
  logic [31:0]        fmt;
  logic               big;
  logic               out_valid_r;
  logic [127:0]       out_data_r;
  logic [2:0]         out_plane_r;
  logic               out_degen_r;

  always_comb begin
    for (int k = 0; k < 4; k++) elem[k] = in_tdata[32*k +: 32];
  end

  // plane sums from one stored column and, except for the near plane, the trigger column
  always_comb begin
    logic signed [32:0] va, vb;
    logic [1:0]         oc;
    oc = fpe_pkg::plane_other(cmd.plane);
    for (int k = 0; k < 4; k++) begin
      vb = {store_r[oc][k][31], store_r[oc][k]};
      va = fpe_pkg::plane_use3(cmd.plane) ? {c3_r[k][31], c3_r[k]} : 33'sd0;
      v_new[k] = fpe_pkg::plane_sub(cmd.plane) ? va - vb : va + vb;
    end
  end

  assign sel_v   = v_r[cmd.k];
  assign sel_mag = sel_v[32] ? 33'(-sel_v) : 33'(sel_v);
  assign sq_w    = sel_mag * sel_mag;

  assign rem2  = {rem_r[REM_W-3:0], x_r[X_W-1 -: 2]};
  assign trial = REM_W'({root_r, 2'b01});

  assign dvs = (RT_W+2)'({root_r, 1'b0});
  assign dr2 = {dr_r[RT_W:0], num_r[NW-1]};

  always_comb begin
    if (neg_r) begin
      big = ovf_r || q_r[32] || q_r[31];
      fmt = big ? 32'h8000_0000 : (32'd0 - q_r[31:0]);
    end else begin
      big = ovf_r || q_r[32] || (q_r[31:0] >= 32'h7FFF_FFFF);
      fmt = big ? 32'h7FFF_FFFF : q_r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col_we) begin
      for (int k = 0; k < 4; k++) store_r[in_col][k] <= elem[k];
    end
    if (cmd.load_c3) begin
      for (int k = 0; k < 4; k++) c3_r[k] <= elem[k];
    end
    if (cmd.form_v) begin
      for (int k = 0; k < 4; k++) v_r[k] <= v_new[k];
      acc_r <= '0;
    end
    if (cmd.sq_step) begin
      if (cmd.k != fpe_pkg::ELEM_LAST) prod_r <= sq_w;
      if (cmd.k != 2'd0) acc_r <= acc_r + prod_r;
    end
    if (cmd.sqrt_start) begin
      x_r    <= X_W'({acc_r, 32'd0});
      rem_r  <= '0;
      root_r <= '0;
    end
    if (cmd.sqrt_step) begin
      x_r <= {x_r[X_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        rem_r  <= rem2 - trial;
        root_r <= {root_r[RT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem2;
        root_r <= {root_r[RT_W-2:0], 1'b0};
      end
    end
    if (cmd.div_start) begin
      num_r <= NW'({sel_mag, {(FRAC_BITS + 17){1'b0}}}) + NW'(root_r);
      dr_r  <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      neg_r <= sel_v[32];
    end
    if (cmd.div_step) begin
      num_r <= {num_r[NW-2:0], 1'b0};
      ovf_r <= ovf_r | q_r[32];
      if (dr2 >= dvs) begin
        dr_r <= dr2 - dvs;
        q_r  <= {q_r[31:0], 1'b1};
      end else begin
        dr_r <= dr2;
        q_r  <= {q_r[31:0], 1'b0};
      end
    end
    if (cmd.div_save) res_r[cmd.k] <= fmt;
    if (cmd.out_load) begin
      out_plane_r <= cmd.plane;
      out_degen_r <= sts.s_zero;
      for (int k = 0; k < 4; k++) out_data_r[32*k +: 32] <= sts.s_zero ? 32'd0 : res_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.s_zero   = (acc_r == '0);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_degen_r, out_plane_r};
  assign out_tlast  = (out_plane_r == fpe_pkg::PLANE_LAST);

endmodule

// File: rtl/core/frustum_plane_extraction_core.sv
// Frustum plane extraction, left-handed convention. Columns 0 to 2 of the
// view-projection matrix are stored; column 3 starts six plane results (left,
// right, bottom, top, near, far). No column is taken while planes are being
// computed. Each plane uses a shared bit-pair square root of 49 steps and four
// serial divisions of FRAC_BITS + 51 steps. A degenerate plane skips root and
// divisions. Column 0 to 2 must be written before the first column 3. Depends
// on fpe_pkg, fpe_ctrl and fpe_dp.
module frustum_plane_extraction_core #(
  parameter int FRAC_BITS = fpe_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // elem_x, elem_y, elem_z, elem_w
  input  logic [1:0]   in_tuser,   // column_index
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // normal_x, normal_y, normal_z, plane_offset
  output logic [3:0]   out_tuser,  // plane_id[2:0], degenerate
  output logic         out_tlast
);

  fpe_pkg::cmd_t cmd;
  fpe_pkg::sts_t sts;

  fpe_ctrl #(.FRAC_BITS(FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_col    (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpe_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_col     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// File: tb/frustum_plane_extraction_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for frustum_plane_extraction_core: streams matrix columns,
// predicts the six normalized planes per trigger column and compares each result.
// Depends on fpe_pkg and the core RTL.
module frustum_plane_extraction_core_tb;

  localparam int FB        = 16;
  localparam int PLANE_CYC = 56 + 4 * (FB + 53);
  localparam longint LIMIT = 64'd4000000;

  typedef enum logic [2:0] {
    PL_LEFT, PL_RIGHT, PL_BOTTOM, PL_TOP, PL_NEAR, PL_FAR
  } plane_e;

  typedef struct packed {
    logic [2:0]  id;
    logic [31:0] nx, ny, nz, ofs;
    logic        degen, last;
  } plane_t;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [127:0] out_tdata;
  logic [3:0]   out_tuser;
  logic         out_tlast;

  plane_t      plane_q[$];
  logic [31:0] col_mem[3][4];
  int          n_err = 0, n_items = 0, n_planes = 0, n_degen = 0;
  longint      cyc = 0;
  int          burst_left = 0;
  bit          stall_mode = 0;

  frustum_plane_extraction_core #(.FRAC_BITS(FB)) DUT (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("timeout at cycle %0d, %0d planes outstanding", cyc, plane_q.size());
      $display("frustum_plane_extraction_core: mismatch");
      $finish;
    end
  end

  // floor(sqrt(x)) bit by bit
  function automatic logic [63:0] isqrt128(logic [127:0] x);
    logic [63:0]  r;
    logic [127:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = {64'd0, r | (64'd1 << b)};
      if (x >= t * t) r = r | (64'd1 << b);
    end
    return r;
  endfunction

  function automatic logic [31:0] norm_scale(longint v, logic [63:0] m);
    logic [127:0] mag, num, q;
    mag = (v < 0) ? 128'(-v) : 128'(v);
    num = ((mag << (FB + 16)) << 1) + {64'd0, m};
    q = num / {63'd0, m, 1'b0};
    if (v < 0) return (q >= 128'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q >= 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  task automatic predict_planes(logic [127:0] c3);
    longint      a, o, v[4];
    logic [127:0] s;
    logic [63:0] m;
    plane_t      pl;
    for (int p = 0; p < 6; p++) begin
      s = '0;
      for (int k = 0; k < 4; k++) begin
        a = (p != PL_NEAR) ? longint'($signed(c3[32*k +: 32])) : 0;
        o = longint'($signed(col_mem[(p < 2) ? 0 : (p < 4) ? 1 : 2][k]));
        v[k] = p[0] ? a - o : a + o;
        if (k < 3) s += 128'(v[k] < 0 ? -v[k] : v[k]) * 128'(v[k] < 0 ? -v[k] : v[k]);
      end
      pl.id = 3'(p);
      pl.last = (p == PL_FAR);
      pl.degen = (s == 0);
      if (s == 0) begin
        {pl.nx, pl.ny, pl.nz, pl.ofs} = '0;
      end else begin
        m = isqrt128(s << 32);
        pl.nx = norm_scale(v[0], m);
        pl.ny = norm_scale(v[1], m);
        pl.nz = norm_scale(v[2], m);
        pl.ofs = norm_scale(v[3], m);
      end
      plane_q.push_back(pl);
    end
  endtask

  // receiver stalls follow a slowly changing pattern
  always @(posedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
  end

  always @(posedge clk) begin
    plane_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[2:0], out_tdata[31:0], out_tdata[63:32], out_tdata[95:64],
             out_tdata[127:96], out_tuser[3], out_tlast};
      n_planes++;
      if (got.degen) n_degen++;
      if (plane_q.size() == 0) begin
        $display("%0t: unexpected plane %h", $time, got);
        n_err++;
      end else begin
        want = plane_q.pop_front();
        if (got !== want) begin
          $display("%0t: plane exp id=%0d n=%h %h %h d=%h dg=%b l=%b", $time, want.id,
                   want.nx, want.ny, want.nz, want.ofs, want.degen, want.last);
          $display("%0t: plane got id=%0d n=%h %h %h d=%h dg=%b l=%b", $time, got.id,
                   got.nx, got.ny, got.nz, got.ofs, got.degen, got.last);
          n_err++;
        end
      end
    end
  end

  task automatic send_column(logic [1:0] col, logic [31:0] x, y, z, w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1;
    in_tuser <= col;
    in_tdata <= {w, z, y, x};
    do @(posedge clk); while (!in_tready);
    n_items++;
    if (col == fpe_pkg::COL_TRIGGER) predict_planes({w, z, y, x});
    else begin
      col_mem[col][0] = x; col_mem[col][1] = y;
      col_mem[col][2] = z; col_mem[col][3] = w;
    end
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (plane_q.size() != 0) @(posedge clk);
    repeat (PLANE_CYC) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_elem();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4: return 32'($signed($urandom_range(0, 8191)) - 4096);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    // identity: clean unit planes
    send_column(0, 32'h10000, 0, 0, 0);
    send_column(1, 0, 32'h10000, 0, 0);
    send_column(2, 0, 0, 32'h10000, 0);
    send_column(3, 0, 0, 0, 32'h10000);
    // zero normal everywhere
    send_column(0, 0, 0, 0, 0);
    send_column(1, 0, 0, 0, 32'h1234);
    send_column(2, 0, 0, 0, 0);
    send_column(3, 0, 0, 0, 32'h7FFF_FFFF);
    // extreme values, offset saturates
    send_column(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_column(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_column(2, 32'h1, 0, 0, 32'h8000_0000);
    send_column(3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h7FFF_FFFF);
    // trigger again with stored columns kept
    send_column(3, 32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000);
    send_column(0, 32'h1, 32'h1, 32'h1, 32'h8000_0000);
    send_column(3, 0, 0, 0, 32'h7FFF_FFFF);
    drain();
  endtask

  task automatic test_random();
    int steps;
    for (int it = 0; it < 72; it++) begin
      steps = $urandom_range(0, 9);
      if (steps < 7) begin
        for (int c = 0; c < 4; c++)
          send_column(2'(c), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem());
      end else begin
        // partial rewrites then a trigger
        repeat ($urandom_range(0, 3))
          send_column(2'($urandom_range(0, 2)), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem());
        send_column(fpe_pkg::COL_TRIGGER, rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem());
      end
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random();
    $display("sent %0d columns, checked %0d planes (%0d degenerate)",
             n_items, n_planes, n_degen);
    if (n_err == 0 && plane_q.size() == 0) begin
      $display("frustum_plane_extraction_core: match");
    end else begin
      $display("frustum_plane_extraction_core: mismatch");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/fpe_pkg.sv
rtl/core/fpe_ctrl.sv
rtl/core/fpe_dp.sv
rtl/core/frustum_plane_extraction_core.sv
tb/frustum_plane_extraction_core_tb.sv
